FILE: rtl/kmh_pkg.sv
// Package for the bounded max-heap core that keeps the smallest distances.
// Holds the slot type, the stream widths and the command and status words
// shared by the controller, the datapath and the top level.
package kmh_pkg;

  localparam int DIST_W   = 16;
  localparam int ID_W     = 16;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 56;

  localparam logic [DIST_W-1:0] DIST_INF = 16'd40960;

  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{vld: 1'b0, id: '0, distance: DIST_INF};

  typedef enum logic [1:0] {
    RD_ROOT  = 2'd0,
    RD_CHILD = 2'd1,
    RD_SWAP  = 2'd2,
    RD_EMIT  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    reject;
    logic    accept;
    logic    wr_x;
    logic    wr_child;
    logic    swap_wr;
    logic    emit_next;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic is_drain;
    logic root_less;
    logic child_in;
    logic go_down;
    logic end_one;
    logic emit_last;
  } sts_t;

endpackage

FILE: rtl/kmh_ctrl.sv
// Controller state machine for the bounded max-heap core.
// Sequences offers, sift-down steps, drain swaps and the emit walk.
// Depends on kmh_pkg for the command and status words.
module kmh_ctrl import kmh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_func,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ROOT_RD  = 9'b000000010,
    S_ROOT_CMP = 9'b000000100,
    S_SIFT_RD  = 9'b000001000,
    S_SIFT_CMP = 9'b000010000,
    S_SWAP_RD  = 9'b000100000,
    S_SWAP_WR  = 9'b001000000,
    S_EMIT_RD  = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t sift_done_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);

  always_comb begin
    if (!sts.is_drain) begin
      sift_done_next = S_OUT;
    end else if (sts.end_one) begin
      sift_done_next = S_EMIT_RD;
    end else begin
      sift_done_next = S_SWAP_RD;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = (s_func == FUNC_DRAIN) ? S_SWAP_RD : S_ROOT_RD;
        end
      end
      S_ROOT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ROOT;
        state_next = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        if (sts.root_less) begin
          cmd.accept = 1'b1;
          state_next = S_SIFT_RD;
        end else begin
          cmd.reject = 1'b1;
          state_next = S_OUT;
        end
      end
      S_SIFT_RD: begin
        if (sts.child_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CHILD;
          state_next = S_SIFT_CMP;
        end else begin
          cmd.wr_x   = 1'b1;
          state_next = sift_done_next;
        end
      end
      S_SIFT_CMP: begin
        if (sts.go_down) begin
          cmd.wr_child = 1'b1;
          state_next   = S_SIFT_RD;
        end else begin
          cmd.wr_x   = 1'b1;
          state_next = sift_done_next;
        end
      end
      S_SWAP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SWAP;
        state_next = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        cmd.swap_wr = 1'b1;
        state_next  = S_SIFT_RD;
      end
      S_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_EMIT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) begin
          if (!sts.is_drain) begin
            state_next = S_IDLE;
          end else if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/kmh_dp.sv
// Datapath for the bounded max-heap core: slot memory with written flags,
// the sifting element, heap pointers and the result payload.
// Depends on kmh_pkg for the slot type and the command and status words.
module kmh_dp import kmh_pkg::*; #(
  parameter int KEEP = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                s_func,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  localparam int AW = $clog2(KEEP + 1);

  entry_t mem [KEEP+1];
  logic [KEEP:0] wflag;

  entry_t a_raw;
  entry_t b_raw;
  logic   a_flag;
  logic   b_flag;
  entry_t a_ent;
  entry_t b_ent;

  entry_t        x;
  logic          func_q;
  logic          acc_q;
  logic [DIST_W-1:0] worst_q;
  logic [AW-1:0] hole;
  logic [AW-1:0] bound;
  logic [AW-1:0] end_ptr;
  logic [AW-1:0] emit_ptr;

  logic [AW:0]   left_idx;
  logic [AW:0]   right_idx;
  logic          right_in;
  logic          take_right;
  entry_t        chosen;
  logic [AW-1:0] chosen_idx;

  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  assign a_ent = a_flag ? a_raw : EMPTY_ENTRY;
  assign b_ent = b_flag ? b_raw : EMPTY_ENTRY;

  assign left_idx   = {hole, 1'b0};
  assign right_idx  = {hole, 1'b1};
  assign right_in   = (right_idx <= {1'b0, bound});
  assign take_right = right_in && (b_ent.distance > a_ent.distance);
  assign chosen     = take_right ? b_ent : a_ent;
  assign chosen_idx = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  assign sts.is_drain  = func_q;
  assign sts.root_less = (x.distance < a_ent.distance);
  assign sts.child_in  = (left_idx <= {1'b0, bound});
  assign sts.go_down   = (chosen.distance > x.distance);
  assign sts.end_one   = (end_ptr == AW'(1));
  assign sts.emit_last = (emit_ptr == AW'(KEEP));

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:  ra = AW'(1);
      RD_CHILD: ra = left_idx[AW-1:0];
      RD_SWAP:  ra = AW'(1);
      RD_EMIT:  ra = emit_ptr;
      default:  ra = AW'(1);
    endcase
    case (cmd.rd_sel)
      RD_CHILD: rb = right_in ? right_idx[AW-1:0] : AW'(1);
      RD_SWAP:  rb = end_ptr;
      default:  rb = AW'(1);
    endcase
  end

  assign we = cmd.wr_x | cmd.wr_child | cmd.swap_wr;
  assign wa = cmd.swap_wr ? end_ptr : hole;

  always_comb begin
    if (cmd.wr_x) begin
      wd = x;
    end else if (cmd.swap_wr) begin
      wd = a_ent;
    end else begin
      wd = chosen;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      a_raw <= mem[ra];
      b_raw <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wflag <= '0;
    end else if (we) begin
      wflag[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_flag <= wflag[ra];
      b_flag <= wflag[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_q     <= s_func;
      x.distance <= s_tdata[DIST_W-1:0];
      x.id       <= s_tdata[DIST_W+ID_W-1:DIST_W];
      x.vld      <= 1'b1;
      hole       <= AW'(1);
      bound      <= AW'(KEEP);
      end_ptr    <= AW'(KEEP);
      emit_ptr   <= AW'(1);
    end
    if (cmd.reject) begin
      acc_q   <= 1'b0;
      worst_q <= a_ent.distance;
    end
    if (cmd.accept) begin
      acc_q <= 1'b1;
    end
    if (cmd.wr_child) begin
      hole <= chosen_idx;
    end
    if (cmd.swap_wr) begin
      x       <= b_ent;
      hole    <= AW'(1);
      bound   <= end_ptr - AW'(1);
      end_ptr <= end_ptr - AW'(1);
    end
    if (cmd.emit_next) begin
      emit_ptr <= emit_ptr + AW'(1);
    end
    if (we && (wa == AW'(1))) begin
      worst_q <= wd.distance;
    end
  end

  always_comb begin
    if (func_q == FUNC_DRAIN) begin
      m_tdata = {6'b0, a_ent.vld, a_ent.id, a_ent.distance, DIST_INF, 1'b0};
      m_tlast = sts.emit_last;
    end else begin
      m_tdata = {6'b0, 1'b0, {ID_W{1'b0}}, {DIST_W{1'b0}}, worst_q, acc_q};
      m_tlast = 1'b1;
    end
  end

endmodule

FILE: rtl/k_smallest_max_heap_core.sv
// Offer: the root is read and compared with the offer; a rejected offer goes
// straight to the result, an accepted one first sifts down the heap, with one
// two-port read and one write of the slot memory per level.
// Drain: one swap and a sift for every slot but the root, then the emit walk
// reads out one word per slot; one item is in flight at a time.
// Reset (synchronous, rst high) marks every slot empty.
module k_smallest_max_heap_core import kmh_pkg::*; #(
  parameter int KEEP = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // dist_req[15:0], item_index[31:16]
  input  logic                s_tuser,  // func
  output logic                m_tvalid,
  input  logic                m_tready,
  // accepted[0], worst_dist[16:1], entry_dist[32:17], entry_index[48:33],
  // entry_valid[49], zero fill above
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  cmd_t cmd;
  sts_t sts;

  kmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_func   (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmh_dp #(
    .KEEP (KEEP)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_func  (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

FILE: dv/k_smallest_max_heap_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded max-heap core. It keeps its own copy of the slot heap,
// predicts every output word from the accepted input words and compares them.
// It depends on kmh_pkg for the slot type, the stream widths and the func codes.
module k_smallest_max_heap_checker import kmh_pkg::*; #(
  parameter int KEEP = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // dist_req[15:0], item_index[31:16]
  input  logic                s_tuser,  // func
  input  logic                m_tvalid,
  input  logic                m_tready,
  // accepted[0], worst_dist[16:1], entry_dist[32:17], entry_index[48:33],
  // entry_valid[49], zero fill above
  input  logic [M_DATA_W-1:0] m_tdata,
  input  logic                m_tlast,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int WORST_LSB = 1;
  localparam int ENTRY_DIST_LSB = WORST_LSB + DIST_W;
  localparam int ENTRY_ID_LSB = ENTRY_DIST_LSB + DIST_W;
  localparam int ENTRY_VLD_BIT = ENTRY_ID_LSB + ID_W;

  typedef struct {
    logic              accepted;
    logic [DIST_W-1:0] worst_dist;
    logic [DIST_W-1:0] entry_dist;
    logic [ID_W-1:0]   entry_index;
    logic              entry_valid;
    logic              last;
  } heap_word_t;

  entry_t     slots [1:KEEP];
  heap_word_t expected_words [$];

  function automatic void clear_slots();
    for (int i = 1; i <= KEEP; i++) slots[i] = EMPTY_ENTRY;
  endfunction

  function automatic void swap_slots(int a, int b);
    entry_t held;
    held = slots[a];
    slots[a] = slots[b];
    slots[b] = held;
  endfunction

  function automatic void sift_root(int bound);
    int parent;
    int child;
    parent = 1;
    child = 2;
    while (child <= bound) begin
      if (child + 1 <= bound && slots[child + 1].distance > slots[child].distance) child++;
      if (slots[child].distance > slots[parent].distance) begin
        swap_slots(parent, child);
        parent = child;
        child = 2 * parent;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void predict_words(logic func, logic [DIST_W-1:0] cand_dist,
                                        logic [ID_W-1:0] id);
    heap_word_t w;
    int         heap_end;
    w = '{default: '0};
    if (func == FUNC_OFFER) begin
      if (slots[1].distance > cand_dist) begin
        slots[1] = '{vld: 1'b1, id: id, distance: cand_dist};
        sift_root(KEEP);
        w.accepted = 1'b1;
      end
      w.worst_dist = slots[1].distance;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      heap_end = KEEP;
      for (int i = 1; i < KEEP; i++) begin
        swap_slots(1, heap_end);
        heap_end--;
        sift_root(heap_end);
      end
      for (int i = 1; i <= KEEP; i++) begin
        w.worst_dist = DIST_INF;
        w.entry_dist = slots[i].distance;
        w.entry_index = slots[i].id;
        w.entry_valid = slots[i].vld;
        w.last = (i == KEEP);
        expected_words.push_back(w);
      end
      clear_slots();
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    heap_word_t want;
    if (rst) begin
      clear_slots();
      expected_words.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual %h last %b",
                   $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("accepted", 16'(want.accepted), 16'(m_tdata[0]));
          check_field("worst_dist", want.worst_dist, m_tdata[WORST_LSB +: DIST_W]);
          check_field("entry_dist", want.entry_dist, m_tdata[ENTRY_DIST_LSB +: DIST_W]);
          check_field("entry_index", want.entry_index, m_tdata[ENTRY_ID_LSB +: ID_W]);
          check_field("entry_valid", 16'(want.entry_valid), 16'(m_tdata[ENTRY_VLD_BIT]));
          check_field("last", 16'(want.last), 16'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_words(s_tuser, s_tdata[DIST_W-1:0], s_tdata[DIST_W +: ID_W]);
      end
    end
    outstanding = expected_words.size();
  end

endmodule

FILE: dv/k_smallest_max_heap_core_test.sv
`timescale 1ns / 1ps
// Top of the testbench for the bounded max-heap core: clock, reset, input
// stimulus, output back-pressure and the verdict. It uses kmh_pkg and the
// checker module, which predicts and compares every output word.
module k_smallest_max_heap_core_test;
  import kmh_pkg::*;

  localparam int KEEP = 20;
  localparam int RANDOM_WORDS = 120;
  localparam int HOLD_START = 800;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 40;
  localparam longint TIMEOUT_NS = 4_000_000;

  typedef enum int {DIST_ANY, DIST_FINITE, DIST_TIES, DIST_NEAR_INF} dist_mode_t;
  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_TOGGLE} ready_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;  // dist_req[15:0], item_index[31:16]
  logic                s_tuser = 1'b0;  // func
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // accepted[0], worst_dist[16:1], entry_dist[32:17], entry_index[48:33],
  // entry_valid[49], zero fill above
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;
  int                  mismatches;
  int                  outstanding;
  int                  burst_left = 0;
  int                  words_sent = 0;

  k_smallest_max_heap_core #(.KEEP(KEEP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  k_smallest_max_heap_checker #(.KEEP(KEEP)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [DIST_W-1:0] pick_dist(dist_mode_t mode);
    case (mode)
      DIST_FINITE:   return DIST_W'($urandom_range(0, DIST_INF - 1));
      DIST_TIES:     return DIST_W'(16'h0400 * $urandom_range(0, 7));
      DIST_NEAR_INF: return DIST_W'($urandom_range(DIST_INF - 8, DIST_INF + 8));
      default:       return DIST_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic func, input logic [DIST_W-1:0] cand_dist,
                           input logic [ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {id, cand_dist};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  initial begin : receiver
    ready_mode_t mode;
    int          seg_left;
    int          cycle_count;
    mode = READY_ALWAYS;
    seg_left = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == HOLD_START) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 100);
      end
      seg_left--;
      case (mode)
        READY_ALWAYS: m_tready <= 1'b1;
        READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
        READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:      m_tready <= ~m_tready;
      endcase
    end
  end

  initial begin : stimulus
    dist_mode_t mode;
    int         goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Draining an empty store shows every slot empty; offers at or above
    // infinity are rejected while empty slots remain; ties never swap.
    send_word(FUNC_DRAIN, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_OFFER, DIST_INF, 16'h1234);
    send_word(FUNC_OFFER, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_OFFER, 16'h0000, 16'hFFFF);
    send_word(FUNC_OFFER, DIST_INF - 1, 16'h0000);
    send_word(FUNC_OFFER, 16'h1000, 16'h0001);
    send_word(FUNC_OFFER, 16'h1000, 16'h0002);
    send_word(FUNC_OFFER, 16'h1000, 16'h0003);
    send_word(FUNC_OFFER, 16'h8000, 16'h8001);
    send_word(FUNC_OFFER, 16'h2AAA, 16'h5555);
    send_word(FUNC_OFFER, 16'h1555, 16'hAAAA);
    send_word(FUNC_DRAIN, 16'h0000, 16'h0000);

    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      if ($urandom_range(0, 4) != 0) begin
        mode = dist_mode_t'($urandom_range(0, 3));
        repeat ($urandom_range(KEEP - 2, KEEP + 12)) begin
          send_word(FUNC_OFFER, pick_dist(mode), ID_W'($urandom));
        end
        send_word(FUNC_DRAIN, DIST_W'($urandom), ID_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(logic'($urandom_range(0, 1)), pick_dist(DIST_ANY), ID_W'($urandom));
        end
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
